FILE: design/cone_isolation_sum_unit_defines.svh
// ----------------------------------------------------------------------------
// cone isolation sum unit assertion macros
// shared property forms for the checker of the isolation block
// ----------------------------------------------------------------------------
`ifndef CONE_ISOLATION_SUM_UNIT_DEFINES_SVH
`define CONE_ISOLATION_SUM_UNIT_DEFINES_SVH

// same-cycle implication
`define CISU_ASSERT_SAME(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("cone isolation check failed");

// next-cycle implication
`define CISU_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("cone isolation check failed");

`endif

FILE: design/cisu_pkg.sv
// ----------------------------------------------------------------------------
// cone isolation sum package
// shared types, register codes and constants of the isolation block
// ----------------------------------------------------------------------------
`default_nettype none

package cisu_pkg;

  // command codes
  localparam logic CMD_REF  = 1'b0;
  localparam logic CMD_CAND = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_CONE_RADIUS_SQ  = 3'd0;
  localparam logic [2:0] REG_CHARGED_VETO_SQ = 3'd1;
  localparam logic [2:0] REG_NEUTRAL_VETO_SQ = 3'd2;
  localparam logic [2:0] REG_CHARGED_PT_MIN  = 3'd3;
  localparam logic [2:0] REG_NEUTRAL_PT_MIN  = 3'd4;

  // register reset values
  localparam logic [19:0] CONE_RADIUS_SQ_RST  = 20'd94372;
  localparam logic [19:0] CHARGED_VETO_SQ_RST = 20'd0;
  localparam logic [19:0] NEUTRAL_VETO_SQ_RST = 20'd104;
  localparam logic [15:0] CHARGED_PT_MIN_RST  = 16'd20;
  localparam logic [15:0] NEUTRAL_PT_MIN_RST  = 16'd50;

  // particle type codes
  localparam logic [7:0] PDG_PION   = 8'd211;
  localparam logic [7:0] PDG_PHOTON = 8'd22;
  localparam logic [7:0] PDG_K0L    = 8'd130;

  // pi with 16 fraction bits
  localparam longint PI_Q16 = 205887;

  localparam logic [25:0] OUT_SUM_MAX = 26'h3FF_FFFF;
  localparam logic [15:0] RATIO_MAX   = 16'hFFFF;
  localparam int          QUOT_W      = 16;
  localparam int          DIV_CNT_W   = $clog2(QUOT_W);

  // queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [19:0] cone_radius_sq;
    logic [19:0] charged_veto_sq;
    logic [19:0] neutral_veto_sq;
    logic [15:0] charged_pt_min;
    logic [15:0] neutral_pt_min;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/cisu_queue.sv
// ----------------------------------------------------------------------------
// cone isolation queue
// short register queue that decouples the front pipeline from the divider
// ----------------------------------------------------------------------------
`default_nettype none

module cisu_queue #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/cisu_front.sv
// ----------------------------------------------------------------------------
// cone isolation front
// three-stage pipeline: angular distance, squares, cone test and running sum
// ----------------------------------------------------------------------------
`default_nettype none

module cisu_front #(
  parameter int ANGLE_FRAC_BITS = 10,
  parameter int SUM_WIDTH       = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd,
  input  logic signed [13:0]          eta,
  input  logic signed [12:0]          phi,
  input  logic [15:0]                 pt,
  input  logic signed [1:0]           charge,
  input  logic [7:0]                  pdg_abs,
  input  logic                        last,
  input  cisu_pkg::cfg_t              cfg,
  input  logic [cisu_pkg::QCNT_W-1:0] q_count,
  output logic                        q_push,
  output logic [SUM_WIDTH+15:0]       q_data
);

  import cisu_pkg::*;

  localparam int PI_UNITS = int'((PI_Q16 + (longint'(1) << (15 - ANGLE_FRAC_BITS)))
                                 >> (16 - ANGLE_FRAC_BITS));
  localparam logic signed [15:0] PI_S     = 16'(PI_UNITS);
  localparam logic signed [15:0] NEG_PI_S = 16'(-PI_UNITS);
  localparam logic signed [15:0] TWO_PI_S = 16'(2 * PI_UNITS);

  // reference
  logic signed [13:0] ref_eta;
  logic signed [12:0] ref_phi;

  logic               accept;
  logic signed [14:0] deta;
  logic [14:0]        deta_abs;
  logic signed [15:0] dphi_raw;
  logic signed [15:0] dphi;
  logic [15:0]        dphi_abs;
  logic               chg_ok;
  logic               neu_ok;

  // stage 1
  logic        s1_valid;
  logic        s1_cmd;
  logic        s1_last;
  logic [15:0] s1_pt;
  logic        s1_chg;
  logic        s1_neu;
  logic [13:0] s1_ae;
  logic [12:0] s1_ap;

  // stage 2
  logic        s2_valid;
  logic        s2_cmd;
  logic        s2_last;
  logic [15:0] s2_pt;
  logic        s2_chg;
  logic        s2_neu;
  logic [27:0] s2_ae2;
  logic [25:0] s2_ap2;

  logic [28:0] dr2;
  logic        in_cone;
  logic        add_hit;

  // stage 3
  logic        s3_valid;
  logic        s3_cmd;
  logic        s3_last;
  logic [15:0] s3_pt;
  logic        s3_add;

  logic [SUM_WIDTH-1:0] sum_acc;
  logic [SUM_WIDTH-1:0] sum_acc_next;
  logic [SUM_WIDTH:0]   sum_wide;
  logic [15:0]          ref_pt;
  logic [15:0]          ref_pt_next;

  logic [1:0]        lasts_in_flight;
  logic [QCNT_W:0]   occupancy;

  // every last item in flight holds a queue slot in advance
  assign lasts_in_flight = 2'(s1_valid && s1_last) + 2'(s2_valid && s2_last)
                         + 2'(s3_valid && s3_last);
  assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(lasts_in_flight);
  assign full      = (occupancy >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept    = push && !full;

  always_comb begin
    deta     = {eta[13], eta} - {ref_eta[13], ref_eta};
    deta_abs = deta[14] ? 15'(-deta) : 15'(deta);
    dphi_raw = {{3{phi[12]}}, phi} - {{3{ref_phi[12]}}, ref_phi};
    // wrap into plus or minus pi
    if (dphi_raw > PI_S) begin
      dphi = dphi_raw - TWO_PI_S;
    end else if (dphi_raw < NEG_PI_S) begin
      dphi = dphi_raw + TWO_PI_S;
    end else begin
      dphi = dphi_raw;
    end
    dphi_abs = dphi[15] ? 16'(-dphi) : 16'(dphi);
    chg_ok   = (charge != 2'sd0) && (pdg_abs == PDG_PION) && (pt > cfg.charged_pt_min);
    neu_ok   = (charge == 2'sd0) && ((pdg_abs == PDG_PHOTON) || (pdg_abs == PDG_K0L))
               && (pt > cfg.neutral_pt_min);
  end

  always_comb begin
    dr2     = 29'(s2_ae2) + 29'(s2_ap2);
    in_cone = dr2 < 29'(cfg.cone_radius_sq);
    add_hit = (s2_cmd == CMD_CAND) && in_cone
              && ((s2_chg && (dr2 > 29'(cfg.charged_veto_sq)))
               || (s2_neu && (dr2 > 29'(cfg.neutral_veto_sq))));
  end

  always_comb begin
    sum_wide     = {1'b0, sum_acc} + (SUM_WIDTH+1)'(s3_pt);
    sum_acc_next = sum_acc;
    ref_pt_next  = ref_pt;
    if (s3_cmd == CMD_REF) begin
      sum_acc_next = '0;
      ref_pt_next  = s3_pt;
    end else if (s3_add) begin
      sum_acc_next = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
    end
  end

  assign q_push = s3_valid && s3_last;
  assign q_data = {sum_acc_next, ref_pt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_eta  <= '0;
      ref_phi  <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      sum_acc  <= '0;
      ref_pt   <= '0;
    end else begin
      if (accept && (cmd == CMD_REF)) begin
        ref_eta <= eta;
        ref_phi <= phi;
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (s3_valid) begin
        sum_acc <= sum_acc_next;
        ref_pt  <= ref_pt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd  <= cmd;
    s1_last <= last;
    s1_pt   <= pt;
    s1_chg  <= chg_ok;
    s1_neu  <= neu_ok;
    s1_ae   <= deta_abs[13:0];
    s1_ap   <= dphi_abs[12:0];

    s2_cmd  <= s1_cmd;
    s2_last <= s1_last;
    s2_pt   <= s1_pt;
    s2_chg  <= s1_chg;
    s2_neu  <= s1_neu;
    s2_ae2  <= s1_ae * s1_ae;
    s2_ap2  <= s1_ap * s1_ap;

    s3_cmd  <= s2_cmd;
    s3_last <= s2_last;
    s3_pt   <= s2_pt;
    s3_add  <= add_hit;
  end

endmodule

`default_nettype wire

FILE: design/cisu_back.sv
// ----------------------------------------------------------------------------
// cone isolation back
// radix-2 divider for the isolation ratio and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cisu_back #(
  parameter int SUM_WIDTH = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [SUM_WIDTH+15:0] q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [25:0]           pt_sum,
  output logic [15:0]           iso_ratio,
  output logic                  zero_pt
);

  import cisu_pkg::*;

  localparam int CW = (SUM_WIDTH > 24) ? SUM_WIDTH : 24;
  localparam int OW = (SUM_WIDTH > 26) ? SUM_WIDTH : 26;

  back_state_t state;
  back_state_t state_next;

  logic [SUM_WIDTH-1:0] q_sum;
  logic [15:0]          q_ref;
  logic                 q_zero;
  logic                 q_sat;

  logic [SUM_WIDTH-1:0] sum_h;
  logic [15:0]          divisor;
  logic                 zero_h;
  logic [15:0]          rem;
  logic [QUOT_W-1:0]    shreg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [16:0]          trial;
  logic                 fits;
  logic [OW-1:0]        sum_ext;

  logic out_valid;
  logic out_free;
  logic load_out;
  logic div_step;

  assign q_sum  = q_data[SUM_WIDTH+15:16];
  assign q_ref  = q_data[15:0];
  assign q_zero = (q_ref == 16'd0);
  // quotient would not fit in 16 bits
  assign q_sat  = CW'(q_sum) >= CW'({q_ref, 8'h00});

  assign trial   = {rem, shreg[QUOT_W-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign sum_ext = OW'(sum_h);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = (q_zero || q_sat) ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt == DIV_CNT_W'(QUOT_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    out_free = !out_valid || pop;
    q_pop    = (state == BK_IDLE) && !q_empty;
    div_step = (state == BK_DIV);
    load_out = (state == BK_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sum_h   <= q_sum;
      divisor <= q_ref;
      zero_h  <= q_zero;
      cnt     <= '0;
      rem     <= 16'(q_sum >> 8);
      shreg   <= (q_zero || q_sat) ? RATIO_MAX : {q_sum[7:0], 8'h00};
    end else if (div_step) begin
      cnt   <= cnt + 1'b1;
      rem   <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      shreg <= {shreg[QUOT_W-2:0], fits};
    end
    if (load_out) begin
      pt_sum    <= (sum_ext > OW'(OUT_SUM_MAX)) ? OUT_SUM_MAX : sum_ext[25:0];
      iso_ratio <= shreg;
      zero_pt   <= zero_h;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: design/cone_isolation_sum_unit.sv
// ----------------------------------------------------------------------------
// cone isolation sum unit
// relative isolation of a reference photon in a delta-R cone
//
//   channel   direction  handshake        payload
//   items     in         push / full      cmd eta phi pt charge pdg_abs last
//   results   out        pop / empty      pt_sum iso_ratio zero_pt
//   config    in         cfg_write        cfg_index cfg_data
//
// the front takes one item per cycle while full is low; a candidate passes a 3-stage pipeline
// a last item reaches the 8-entry queue after stages s1, s2 and s3, and the
// divider skips the division for a saturated or zero-pt ratio
// the back pops the next queued sum only after the previous result is loaded
// full rises when queued results plus last items in flight reach 8
// rst is synchronous; it restores the register defaults and clears the reference
// ----------------------------------------------------------------------------
`default_nettype none

module cone_isolation_sum_unit #(
  parameter int ANGLE_FRAC_BITS = 10,
  parameter int SUM_WIDTH       = 26
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic signed [13:0] eta,
  input  logic signed [12:0] phi,
  input  logic [15:0]        pt,
  input  logic signed [1:0]  charge,
  input  logic [7:0]         pdg_abs,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic [25:0]        pt_sum,
  output logic [15:0]        iso_ratio,
  output logic               zero_pt,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  import cisu_pkg::*;

  cfg_t                  cfg;
  logic [QCNT_W-1:0]     q_count;
  logic                  q_push;
  logic [SUM_WIDTH+15:0] q_din;
  logic [SUM_WIDTH+15:0] q_dout;
  logic                  q_empty;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cone_radius_sq  <= CONE_RADIUS_SQ_RST;
      cfg.charged_veto_sq <= CHARGED_VETO_SQ_RST;
      cfg.neutral_veto_sq <= NEUTRAL_VETO_SQ_RST;
      cfg.charged_pt_min  <= CHARGED_PT_MIN_RST;
      cfg.neutral_pt_min  <= NEUTRAL_PT_MIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CONE_RADIUS_SQ:  cfg.cone_radius_sq  <= cfg_data;
        REG_CHARGED_VETO_SQ: cfg.charged_veto_sq <= cfg_data;
        REG_NEUTRAL_VETO_SQ: cfg.neutral_veto_sq <= cfg_data;
        REG_CHARGED_PT_MIN:  cfg.charged_pt_min  <= cfg_data[15:0];
        REG_NEUTRAL_PT_MIN:  cfg.neutral_pt_min  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  cisu_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .SUM_WIDTH       (SUM_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .eta     (eta),
    .phi     (phi),
    .pt      (pt),
    .charge  (charge),
    .pdg_abs (pdg_abs),
    .last    (last),
    .cfg     (cfg),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_din)
  );

  cisu_queue #(
    .WIDTH (SUM_WIDTH + 16),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  cisu_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_dout),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .pt_sum    (pt_sum),
    .iso_ratio (iso_ratio),
    .zero_pt   (zero_pt)
  );

endmodule

`default_nettype wire

FILE: design/cisu_checker.sv
// ----------------------------------------------------------------------------
// cone isolation checker
// port-level properties of the isolation block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "cone_isolation_sum_unit_defines.svh"

module cisu_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [25:0] pt_sum,
  input logic [15:0] iso_ratio,
  input logic        zero_pt
);

  // no result is offered right after reset
  `CISU_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty)

  // a result that is not taken stays on the ports unchanged
  `CISU_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(pt_sum) && $stable(iso_ratio) && $stable(zero_pt))

  // zero reference pt forces the maximum ratio
  `CISU_ASSERT_SAME(a_zero_pt_ratio, clk, rst, !empty && zero_pt, iso_ratio == 16'hFFFF)

  // an empty cone gives a zero ratio
  `CISU_ASSERT_SAME(a_empty_cone_ratio, clk, rst, !empty && !zero_pt && (pt_sum == 26'd0), iso_ratio == 16'd0)

endmodule

bind cone_isolation_sum_unit cisu_checker u_checker (.*);

`default_nettype wire
